FILE: src/ternary_fft_gf4_packed_top_assert.svh
// assertion macros shared by the block, clocked on clk_i and reset by rst_ni
`ifndef TERNARY_FFT_GF4_PACKED_TOP_ASSERT_SVH
`define TERNARY_FFT_GF4_PACKED_TOP_ASSERT_SVH

`ifndef ASSERT_OFF

// same-cycle implication
`define TFG_ASSERT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define TFG_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`else

`define TFG_ASSERT(lbl, ante, cons, msg)
`define TFG_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

FILE: src/tfg_pkg.sv
`timescale 1ns / 1ps
package tfg_pkg;

  // operation codes
  localparam logic [1:0] OP_WRITE = 2'd0;
  localparam logic [1:0] OP_XFORM = 2'd1;
  localparam logic [1:0] OP_READ  = 2'd2;

  // memory port source select
  localparam logic [1:0] SEL_IN = 2'd0;
  localparam logic [1:0] SEL_L  = 2'd1;
  localparam logic [1:0] SEL_M  = 2'd2;
  localparam logic [1:0] SEL_R  = 2'd3;

  // high bit of every element pair
  localparam logic [63:0] HIGH_MASK = 64'haaaa_aaaa_aaaa_aaaa;

  typedef struct packed {
    logic [1:0]  operation;
    logic [12:0] address;
    logic [63:0] write_word;
  } tfg_in_t;

  typedef struct packed {
    logic [63:0] read_word;
    logic        status;
  } tfg_out_t;

  typedef struct packed {
    logic       mem_re;
    logic       mem_we;
    logic [1:0] sel;
    logic       cap_l;
    logic       cap_m;
    logic       cap_r;
    logic       start;
    logic       adv;
    logic       out_load;
    logic       out_from_ram;
    logic       out_status;
  } tfg_cmd_t;

  typedef struct packed {
    logic in_range;
    logic last_bfly;
  } tfg_stat_t;

  function automatic int tfg_pow3(input int k);
    int p;
    p = 1;
    for (int i = 0; i < k; i++) begin
      p = p * 3;
    end
    return p;
  endfunction

endpackage

FILE: src/ternary_fft_gf4_packed_top.sv
`timescale 1ns / 1ps
// write, out-of-range read and unused op: result in the output register next cycle
// in-range read: the registered read of the single-port word store passes through S_RDATA to the output register
// transform: three reads and three writes per butterfly on that port
// one item is in work at a time
// reset clears the controller, the output valid and sets active_vars to 8
// the word store keeps its contents through reset and is not cleared
module ternary_fft_gf4_packed_top
  import tfg_pkg::*;
#(
  parameter int MAX_VARS  = 8,
  parameter int WORD_BITS = 64
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  // configuration: active_vars
  input  logic       cfg_we_i,
  input  logic [3:0] cfg_wdata_i,
  // item input
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  tfg_in_t    in_data_i,
  // result output
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output tfg_out_t   out_data_o
);

  // commands from the sequencer, status back from the datapath
  tfg_cmd_t  cmd;
  tfg_stat_t stat;

  // sequencer: handshakes, output valid and the butterfly schedule
  // (read l, read m, read r, write l, write m, write r)
  tfg_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .op_i        (in_data_i.operation),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  // datapath: config register, range check, stride and base counters,
  // butterfly operand registers, the word store and the output register
  tfg_datapath #(
    .MAX_VARS  (MAX_VARS),
    .WORD_BITS (WORD_BITS)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_data_i   (in_data_i),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .out_data_o  (out_data_o)
  );

endmodule

FILE: src/tfg_ram.sv
`timescale 1ns / 1ps
module tfg_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 6561
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: src/tfg_ctrl.sv
`timescale 1ns / 1ps
`include "ternary_fft_gf4_packed_top_assert.svh"
module tfg_ctrl
  import tfg_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [1:0] op_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  input  tfg_stat_t  stat_i,
  output tfg_cmd_t   cmd_o
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_RDATA = 3'd1;
  localparam logic [2:0] S_XRL   = 3'd2;
  localparam logic [2:0] S_XRM   = 3'd3;
  localparam logic [2:0] S_XRR   = 3'd4;
  localparam logic [2:0] S_XWL   = 3'd5;
  localparam logic [2:0] S_XWM   = 3'd6;
  localparam logic [2:0] S_XWR   = 3'd7;

  logic [2:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       accept;
  tfg_cmd_t   cmd;

  // output slot is free after this edge
  assign in_stall_o = !((state_q == S_IDLE) && (!out_valid_q || !out_stall_i));
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    cmd     = '0;
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          case (op_i)
            OP_WRITE: begin
              cmd.mem_we     = stat_i.in_range;
              cmd.sel        = SEL_IN;
              cmd.out_load   = 1'b1;
              cmd.out_status = !stat_i.in_range;
            end
            OP_READ: begin
              if (stat_i.in_range) begin
                cmd.mem_re = 1'b1;
                cmd.sel    = SEL_IN;
                state_d    = S_RDATA;
              end else begin
                cmd.out_load   = 1'b1;
                cmd.out_status = 1'b1;
              end
            end
            OP_XFORM: begin
              cmd.start = 1'b1;
              state_d   = S_XRL;
            end
            default: begin
              cmd.out_load = 1'b1;
            end
          endcase
        end
      end
      S_RDATA: begin
        cmd.out_load     = 1'b1;
        cmd.out_from_ram = 1'b1;
        state_d          = S_IDLE;
      end
      S_XRL: begin
        cmd.mem_re = 1'b1;
        cmd.sel    = SEL_L;
        state_d    = S_XRM;
      end
      S_XRM: begin
        cmd.mem_re = 1'b1;
        cmd.sel    = SEL_M;
        cmd.cap_l  = 1'b1;
        state_d    = S_XRR;
      end
      S_XRR: begin
        cmd.mem_re = 1'b1;
        cmd.sel    = SEL_R;
        cmd.cap_m  = 1'b1;
        state_d    = S_XWL;
      end
      S_XWL: begin
        cmd.mem_we = 1'b1;
        cmd.sel    = SEL_L;
        cmd.cap_r  = 1'b1;
        state_d    = S_XWM;
      end
      S_XWM: begin
        cmd.mem_we = 1'b1;
        cmd.sel    = SEL_M;
        state_d    = S_XWR;
      end
      S_XWR: begin
        cmd.mem_we = 1'b1;
        cmd.sel    = SEL_R;
        if (stat_i.last_bfly) begin
          cmd.out_load = 1'b1;
          state_d      = S_IDLE;
        end else begin
          cmd.adv = 1'b1;
          state_d = S_XRL;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
    if (cmd.out_load) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign cmd_o       = cmd;

  `TFG_ASSERT(a_load_free_slot, cmd.out_load, !out_valid_q || !out_stall_i, "result overwrites a waiting item")
  `TFG_ASSERT(a_port_exclusive, cmd.mem_we, !cmd.mem_re, "read and write on the store in one cycle")
  `TFG_ASSERT(a_write_in_range, (state_q == S_IDLE) && cmd.mem_we, stat_i.in_range, "out of range write reaches the store")
  `TFG_ASSERT_NEXT(a_xform_starts, accept && (op_i == OP_XFORM), state_q == S_XRL, "transform did not start")

endmodule

FILE: src/tfg_datapath.sv
`timescale 1ns / 1ps
module tfg_datapath
  import tfg_pkg::*;
#(
  parameter int MAX_VARS  = 8,
  parameter int WORD_BITS = 64
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [3:0] cfg_wdata_i,
  input  tfg_in_t    in_data_i,
  input  tfg_cmd_t   cmd_i,
  output tfg_stat_t  stat_o,
  output tfg_out_t   out_data_o
);

  localparam int DEPTH  = tfg_pow3(MAX_VARS);
  localparam int AW     = $clog2(DEPTH);
  localparam int SPAN_W = $clog2(DEPTH + 1);
  localparam int CW     = (SPAN_W > 13) ? SPAN_W : 13;
  localparam logic [WORD_BITS-1:0] HI_M = HIGH_MASK[WORD_BITS-1:0];
  localparam logic [WORD_BITS-1:0] LO_M = HI_M >> 1;

  function automatic logic [(MAX_VARS+1)*SPAN_W-1:0] span_table();
    logic [(MAX_VARS+1)*SPAN_W-1:0] t;
    t = '0;
    for (int k = 0; k <= MAX_VARS; k++) begin
      t[k*SPAN_W +: SPAN_W] = SPAN_W'(tfg_pow3(k));
    end
    return t;
  endfunction

  localparam logic [(MAX_VARS+1)*SPAN_W-1:0] SPAN_TAB = span_table();

  // (h,l) -> (l, h^l) on every pair
  function automatic logic [WORD_BITS-1:0] times_alpha(input logic [WORD_BITS-1:0] x);
    logic [WORD_BITS-1:0] h;
    logic [WORD_BITS-1:0] l;
    h = x & HI_M;
    l = x & LO_M;
    return ((h >> 1) ^ l) | (l << 1);
  endfunction

  logic [3:0]           cfg_q;
  logic [3:0]           nv;
  logic [SPAN_W-1:0]    total;
  logic [CW-1:0]        addr_ext;
  logic [SPAN_W-1:0]    stride_q, base_q, j_q;
  logic [SPAN_W-1:0]    step3, il, im, ir;
  logic                 j_end, base_end;
  logic [WORD_BITS-1:0] l_q, m_q, r_q;
  logic [WORD_BITS-1:0] rdata, wdata, alpha_mr;
  logic [AW-1:0]        mem_addr;
  logic [63:0]          rd_ext;
  tfg_out_t             out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= 4'd8;
    end else if (cfg_we_i) begin
      cfg_q <= cfg_wdata_i;
    end
  end

  // saturate into 1 .. MAX_VARS
  always_comb begin
    if (cfg_q == 4'd0) begin
      nv = 4'd1;
    end else if (cfg_q > 4'(MAX_VARS)) begin
      nv = 4'(MAX_VARS);
    end else begin
      nv = cfg_q;
    end
  end

  assign total    = SPAN_TAB[nv*SPAN_W +: SPAN_W];
  assign addr_ext = CW'(in_data_i.address);

  assign step3    = stride_q + (stride_q << 1);
  assign il       = base_q + j_q;
  assign im       = il + stride_q;
  assign ir       = im + stride_q;
  assign j_end    = (j_q == stride_q - SPAN_W'(1));
  assign base_end = (base_q + step3 == total);

  assign stat_o.in_range  = addr_ext < CW'(total);
  assign stat_o.last_bfly = j_end && base_end && (step3 == total);

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      stride_q <= SPAN_W'(1);
      base_q   <= '0;
      j_q      <= '0;
    end else if (cmd_i.adv) begin
      if (j_end) begin
        j_q <= '0;
        if (base_end) begin
          base_q   <= '0;
          stride_q <= step3;
        end else begin
          base_q <= base_q + step3;
        end
      end else begin
        j_q <= j_q + SPAN_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.cap_l) begin
      l_q <= rdata;
    end
    if (cmd_i.cap_m) begin
      m_q <= rdata;
    end
    if (cmd_i.cap_r) begin
      r_q <= rdata;
    end
  end

  assign alpha_mr = times_alpha(m_q ^ r_q);

  always_comb begin
    case (cmd_i.sel)
      SEL_IN: begin
        mem_addr = addr_ext[AW-1:0];
        wdata    = in_data_i.write_word[WORD_BITS-1:0];
      end
      SEL_L: begin
        mem_addr = il[AW-1:0];
        wdata    = l_q ^ m_q ^ rdata;
      end
      SEL_M: begin
        mem_addr = im[AW-1:0];
        wdata    = l_q ^ r_q ^ alpha_mr;
      end
      SEL_R: begin
        mem_addr = ir[AW-1:0];
        wdata    = l_q ^ m_q ^ alpha_mr;
      end
      default: begin
        mem_addr = addr_ext[AW-1:0];
        wdata    = in_data_i.write_word[WORD_BITS-1:0];
      end
    endcase
  end

  tfg_ram #(
    .WIDTH (WORD_BITS),
    .DEPTH (DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (cmd_i.mem_we),
    .re_i    (cmd_i.mem_re),
    .addr_i  (mem_addr),
    .wdata_i (wdata),
    .rdata_o (rdata)
  );

  always_comb begin
    rd_ext                  = '0;
    rd_ext[WORD_BITS-1:0]   = rdata;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_q.read_word <= cmd_i.out_from_ram ? rd_ext : 64'd0;
      out_q.status    <= cmd_i.out_status;
    end
  end

  assign out_data_o = out_q;

endmodule
